>>> design/rapf_pkg.sv
// Shared types and constants for the rectangle adjacency pair finder.
// No dependencies; rapf_touch and the top level import this package.
`default_nettype none

package rapf_pkg;

	localparam int unsigned MAX_BOXES   = 64;
	localparam int unsigned RESULT_CAP  = 63;
	localparam int unsigned OUT_IDX_W   = 6;
	localparam int unsigned IDX_W       = $clog2(MAX_BOXES);
	localparam int unsigned CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int unsigned RES_CNT_W   = $clog2(RESULT_CAP + 1);
	localparam int unsigned BOX_W       = 128;

	typedef struct packed {
		logic               first_box;
		logic signed [31:0] left_x;
		logic signed [31:0] bottom_y;
		logic signed [31:0] right_x;
		logic signed [31:0] top_y;
	} in_item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] earlier_index;
		logic [OUT_IDX_W-1:0] new_index;
		logic                 store_full;
		logic                 last_pair;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] lx;
		logic signed [31:0] ly;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
	} box_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FULL
	} st_t;

	// Low bits of a store index as carried on the result fields.
	function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [CNT_W-1:0] v);
		logic [CNT_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, v};
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/rapf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rapf_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/rapf_touch.sv
// Edge adjacency comparator shared by every step of the scan.
// Depends on rapf_pkg for the box type.
`default_nettype none

module rapf_touch (
	input  rapf_pkg::box_t a,
	input  rapf_pkg::box_t b,
	output logic           hit
);
	import rapf_pkg::*;

	logic x_edge, y_edge, y_overlap, x_overlap;

	// min(p, q) > max(r, s) is the same as all four cross compares holding.
	always_comb begin
		x_edge    = (a.ux == b.lx) || (b.ux == a.lx);
		y_edge    = (a.uy == b.ly) || (b.uy == a.ly);
		y_overlap = (a.uy > a.ly) && (a.uy > b.ly) && (b.uy > a.ly) && (b.uy > b.ly);
		x_overlap = (a.ux > a.lx) && (a.ux > b.lx) && (b.ux > a.lx) && (b.ux > b.lx);
		hit       = (x_edge && y_overlap) || (y_edge && x_overlap);
	end

endmodule

`default_nettype wire

>>> design/rectangle_adjacency_pair_finder.sv
// Top level of the rectangle adjacency pair finder.
// Depends on rapf_pkg, rapf_ram and rapf_touch.
//
// A box with first_box set empties the store. Each box is then checked against
// every box stored earlier in its set, one stored box per clock while no pair
// waits because the pair side is not ready, through the single read port of the
// box RAM and one shared comparator. Pairs come out in ascending order of
// the earlier index, with last_pair set on the final one; a box with no neighbor
// gives no transfer at all. A box that arrives when the store is full is not
// stored and gives one transfer with store_full and last_pair set.
// The box side is ready only between boxes; the last pair of a box may still
// wait on the output while the next box is accepted.
`default_nettype none

module rectangle_adjacency_pair_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                box_valid,
	output logic                box_ready,
	input  rapf_pkg::in_item_t  box,
	output logic                pair_valid,
	input  logic                pair_ready,
	output rapf_pkg::out_item_t pair
);
	import rapf_pkg::*;

	st_t                  state_q, state_d;
	logic [CNT_W-1:0]     count_q, scan_cnt_q, rd_idx_q, cmp_idx_s1, pend_idx_q, eff_count;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic                 cmp_vld_s1, pend_vld_q, out_vld_q;
	box_t                 nb_q, new_box, rd_box;
	out_item_t            out_q, out_d;
	logic                 accept, out_free, hit;
	logic                 issue, take_hit, stall, push_scan, scan_done, fin, full_done, load_out;

	assign new_box   = '{lx: box.left_x, ly: box.bottom_y, ux: box.right_x, uy: box.top_y};
	assign eff_count = box.first_box ? '0 : count_q;
	assign out_free  = !out_vld_q || pair_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (eff_count >= CNT_W'(MAX_BOXES)) ? ST_FULL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (fin) state_d = ST_IDLE;
			end
			ST_FULL: begin
				if (full_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer strobes.
	always_comb begin
		box_ready = (state_q == ST_IDLE);
		accept    = box_valid && box_ready;
		take_hit  = cmp_vld_s1 && hit && (res_cnt_q < RES_CNT_W'(RESULT_CAP));
		// A new hit must move the held pair out first, since only then is it
		// known that the held pair was not the last one.
		stall     = take_hit && pend_vld_q && !out_free;
		push_scan = take_hit && pend_vld_q && out_free;
		issue     = (state_q == ST_SCAN) && (rd_idx_q < scan_cnt_q) && !stall;
		scan_done = (state_q == ST_SCAN) && (rd_idx_q == scan_cnt_q) && !cmp_vld_s1;
		fin       = (state_q == ST_FLUSH) && (!pend_vld_q || out_free);
		full_done = (state_q == ST_FULL) && out_free;
		load_out  = push_scan || (fin && pend_vld_q) || full_done;

		out_d = out_q;
		if (full_done) begin
			out_d = '{earlier_index: '0, new_index: '0, store_full: 1'b1, last_pair: 1'b1};
		end else if (load_out) begin
			out_d = '{earlier_index: to_out_idx(pend_idx_q),
			          new_index:     to_out_idx(scan_cnt_q),
			          store_full:    1'b0,
			          last_pair:     (state_q == ST_FLUSH)};
		end
	end

	rapf_ram #(
		.WIDTH (BOX_W),
		.DEPTH (MAX_BOXES)
	) u_store (
		.clk   (clk),
		.we    (fin),
		.waddr (scan_cnt_q[IDX_W-1:0]),
		.wdata (nb_q),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_box)
	);

	rapf_touch u_touch (
		.a   (rd_box),
		.b   (nb_q),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			res_cnt_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q    <= eff_count;
				scan_cnt_q <= eff_count;
				rd_idx_q   <= '0;
				pend_vld_q <= 1'b0;
				res_cnt_q  <= '0;
			end
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (!stall) begin
				cmp_vld_s1 <= issue;
			end
			if (take_hit && !stall) begin
				pend_vld_q <= 1'b1;
				res_cnt_q  <= res_cnt_q + RES_CNT_W'(1);
			end
			if (fin) begin
				pend_vld_q <= 1'b0;
				count_q    <= scan_cnt_q + CNT_W'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pair_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nb_q <= new_box;
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (take_hit && !stall) begin
			pend_idx_q <= cmp_idx_s1;
		end
		out_q <= out_d;
	end

	assign pair_valid = out_vld_q;
	assign pair       = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BOXES))
		else $error("box count beyond store depth");

	a_pend_below_new: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (pend_idx_q < scan_cnt_q))
		else $error("held pair index not below new box index");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("held pair outside scan");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair.store_full) |->
			(pair.last_pair && pair.earlier_index == '0 && pair.new_index == '0))
		else $error("malformed store full result");

	a_store_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (count_q == $past(scan_cnt_q) + CNT_W'(1)))
		else $error("box count not advanced after store");

endmodule

`default_nettype wire
